/* hw/rtl/mrs_pkg.sv */
`timescale 1ns / 1ps

package mrs_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CsrIndexWidth = 8;

   typedef logic [TimeWidth-1:0] time_ms_type;

   // Register indexes on the configuration port
   localparam logic [CsrIndexWidth-1:0] CSR_SOFT_TIMEOUT = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_HARD_TIMEOUT = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_SOFT_GAP     = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_HARD_GAP     = 8'd3;

   // Register values after reset
   localparam time_ms_type SOFT_TIMEOUT_RESET = 32'd60000;
   localparam time_ms_type HARD_TIMEOUT_RESET = 32'd180000;
   localparam time_ms_type SOFT_GAP_RESET     = 32'd15000;
   localparam time_ms_type HARD_GAP_RESET     = 32'd30000;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_FAIL     = 3'd1,
      ACT_SOFT     = 3'd2,
      ACT_HARD     = 3'd3,
      ACT_SOFT_THR = 3'd4,
      ACT_HARD_THR = 3'd5
   } action_type;

   typedef struct packed {
      time_ms_type now_ms;
      logic        modem_ready;
      logic        reset_busy;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic        clear_ready;
      time_ms_type soft_resets;
      time_ms_type hard_resets;
   } rsp_type;

   typedef struct packed {
      time_ms_type soft_timeout_ms;
      time_ms_type hard_timeout_ms;
      time_ms_type soft_gap_ms;
      time_ms_type hard_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic        failure_seen;
      time_ms_type failure_start;
      logic        soft_done;
      time_ms_type last_hard_time;
      time_ms_type last_soft_time;
      time_ms_type soft_count;
      time_ms_type hard_count;
   } state_type;

endpackage

/* hw/rtl/mrs_decide.sv */
`timescale 1ns / 1ps

module mrs_decide
   import mrs_pkg::*;
(
   input  req_type   req,
   input  cfg_type   cfg,
   input  state_type state,
   output state_type state_next,
   output rsp_type   rsp
);

   time_ms_type outage;
   time_ms_type since_hard;
   time_ms_type since_soft;
   action_type  action;
   logic        clear;

   assign outage     = req.now_ms - state.failure_start;
   assign since_hard = req.now_ms - state.last_hard_time;
   assign since_soft = req.now_ms - state.last_soft_time;

   always_comb begin
      state_next = state;
      action     = ACT_NONE;
      clear      = 1'b0;
      if (req.modem_ready) begin
         state_next.failure_seen  = 1'b0;
         state_next.failure_start = '0;
         state_next.soft_done     = 1'b0;
      end else if (!state.failure_seen) begin
         state_next.failure_seen  = 1'b1;
         state_next.failure_start = req.now_ms;
         state_next.soft_done     = 1'b0;
         action                   = ACT_FAIL;
      end else if (!req.reset_busy) begin
         // hard check takes priority over soft
         if (outage >= cfg.hard_timeout_ms) begin
            if (since_hard < cfg.hard_gap_ms) begin
               action = ACT_HARD_THR;
            end else begin
               state_next.last_hard_time = req.now_ms;
               state_next.failure_seen   = 1'b0;
               state_next.soft_done      = 1'b0;
               state_next.hard_count     = state.hard_count + 32'd1;
               action                    = ACT_HARD;
            end
         end else if (outage >= cfg.soft_timeout_ms && !state.soft_done) begin
            if (since_soft < cfg.soft_gap_ms) begin
               action = ACT_SOFT_THR;
            end else begin
               state_next.last_soft_time = req.now_ms;
               state_next.soft_done      = 1'b1;
               state_next.soft_count     = state.soft_count + 32'd1;
               action                    = ACT_SOFT;
               clear                     = 1'b1;
            end
         end
      end
   end

   assign rsp.action      = action;
   assign rsp.clear_ready = clear;
   assign rsp.soft_resets = state_next.soft_count;
   assign rsp.hard_resets = state_next.hard_count;

endmodule

/* hw/rtl/modem_recovery_supervisor.sv */
`timescale 1ns / 1ps

// Modem recovery supervisor. Each req_ transfer is one supervision tick
// (time in ms, modem ready, external reset busy) and yields exactly one
// rsp_ transfer with an action code (none, failure detected, soft reset,
// hard reset, soft throttled, hard throttled), a clear_ready strobe that
// goes with a soft reset, and the running soft and hard reset counts
// after the tick. A tick is captured in an input register, decided by
// combinational compare-and-subtract logic against the supervisor state
// and lands in the result register, which holds it until rsp_ready; a
// new tick is taken every cycle while rsp_ready stays high. The state
// update of one tick is pure combinational logic, which is what sets the
// one-tick-per-cycle rate. All time differences wrap modulo
// 2^32. Registers 0..3 (soft timeout, hard timeout, soft gap, hard gap)
// are written over the csr_ port, always ready; writes to other indexes
// are dropped. Write them only while no tick is in flight.
module modem_recovery_supervisor
   import mrs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  time_ms_type              csr_data
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   req_type   req_ff;
   logic      req_vld_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_vld_ff;
   logic      advance;
   logic      req_take;

   // move the captured tick forward when the result register is empty or being read
   assign advance   = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOFT_TIMEOUT: cfg_in.soft_timeout_ms = csr_data;
            CSR_HARD_TIMEOUT: cfg_in.hard_timeout_ms = csr_data;
            CSR_SOFT_GAP:     cfg_in.soft_gap_ms     = csr_data;
            CSR_HARD_GAP:     cfg_in.hard_gap_ms     = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soft_timeout_ms <= SOFT_TIMEOUT_RESET;
         cfg_ff.hard_timeout_ms <= HARD_TIMEOUT_RESET;
         cfg_ff.soft_gap_ms     <= SOFT_GAP_RESET;
         cfg_ff.hard_gap_ms     <= HARD_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register: hold the tick until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_ready) begin
         req_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
   end

   mrs_decide u_decide (
      .req        (req_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .rsp        (rsp_in)
   );

   // supervisor state: advance once per decided tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register: drop valid on a rsp transfer with nothing behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_clear_only_soft: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clear_ready |-> rsp_data.action == ACT_SOFT)
      else $error("clear_ready without soft reset");

   a_hard_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff.hard_count != $past(state_ff.hard_count) |->
         $past(advance) && $past(rsp_in.action) == ACT_HARD)
      else $error("hard count changed without hard reset");

   a_soft_count_inc: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.action == ACT_SOFT |=>
         state_ff.soft_count == $past(state_ff.soft_count) + 32'd1)
      else $error("soft count did not advance by one");

   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      advance |-> !rsp_vld_ff || rsp_ready)
      else $error("result register overwritten while pending");
`endif

endmodule
